// ----- src/fpfa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpfa_pkg
// shared codes for the page frame allocator: operations, status, states
// ----------------------------------------------------------------------------
package fpfa_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_BUILD = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_SHORT    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_UNMAPPED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_BUILD = 2'd2
  } state_t;

  localparam logic [1:0] REG_HEAP_BASE  = 2'd0;
  localparam logic [1:0] REG_HEAP_BYTES = 2'd1;

endpackage

// ----- src/fifo_page_frame_allocator.sv -----
// ----------------------------------------------------------------------------
// fifo_page_frame_allocator
// fifo free list of physical page frames held as next-links in a memory
// ----------------------------------------------------------------------------
// ops: allocate, free and the unused op read the memories on the input beat;
//   allocate marks the head frame mapped; exec writes back free and registers the result
//   once the output slot is free; no new item is taken until idle. build: the sweep
//   writes one frame per cycle, then registers the result; a stalled result holds the block
// reset: synchronous; control state, configuration registers and list pointers cleared,
//   link and mapped memories are not cleared (build clears the mapped bits)
module fifo_page_frame_allocator #(
  parameter int MAX_FRAMES = 8192,
  parameter int PAGE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] frame_address,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] granted_address,
  output logic [2:0]  status
);

  // page size is a power of two, so divide and multiply are shifts
  localparam int PS = $clog2(PAGE_BYTES);
  localparam int IW = $clog2(MAX_FRAMES);
  localparam int LW = $clog2(MAX_FRAMES + 1);
  localparam int XW = 32 - PS;

  // configuration registers
  logic [31:0] heap_base;
  logic [31:0] heap_bytes;

  // list control
  fpfa_pkg::state_t state, state_next;
  fpfa_pkg::op_t    op_q;
  logic [IW-1:0]    idx_q;
  logic             range_ok;
  logic [IW-1:0]    head_index, head_next;
  logic [IW-1:0]    tail_index, tail_next;
  logic             list_empty, empty_next;
  logic [LW-1:0]    frames_in_use_limit, limit_next;
  logic [31:0]      built_base, base_next;
  logic [LW-1:0]    build_cnt, cnt_next;

  // output register
  logic             out_valid_next;
  logic [31:0]      granted_next;
  logic [2:0]       status_next;
  logic             slot_free;

  // memories
  logic [IW-1:0]    link_mem [MAX_FRAMES];
  logic             map_mem  [MAX_FRAMES];
  logic [IW-1:0]    link_rdata;
  logic             map_rdata;
  logic             map_we, map_wd, link_we, rd_en;
  logic [IW-1:0]    map_wa, link_wa, link_wd, map_ra;

  // address decode for free
  logic [31:0]      free_off;
  logic [XW-1:0]    free_idx_full;
  logic             free_in_range;
  logic [XW-1:0]    bytes_frames;
  logic [LW-1:0]    build_frames;
  logic             in_beat;

  assign cfg_ready     = 1'b1;
  assign in_beat       = in_valid && in_ready;
  assign slot_free     = !out_valid || out_ready;

  assign free_off      = frame_address - built_base;
  assign free_idx_full = free_off[31:PS];
  assign free_in_range = 33'(free_idx_full) < 33'(frames_in_use_limit);
  assign map_ra        = free_idx_full[IW-1:0];

  // frames that fit the heap, clamped to the table size
  assign bytes_frames  = heap_bytes[31:PS];
  assign build_frames  = (33'(bytes_frames) > 33'(MAX_FRAMES)) ? LW'(MAX_FRAMES)
                                                               : LW'(bytes_frames);

  always_comb begin
    state_next     = state;
    head_next      = head_index;
    tail_next      = tail_index;
    empty_next     = list_empty;
    limit_next     = frames_in_use_limit;
    base_next      = built_base;
    cnt_next       = build_cnt;
    out_valid_next = out_valid && !out_ready;
    granted_next   = granted_address;
    status_next    = status;
    map_we         = 1'b0;
    map_wa         = idx_q;
    map_wd         = 1'b0;
    link_we        = 1'b0;
    link_wa        = tail_index;
    link_wd        = idx_q;
    in_ready       = (state == fpfa_pkg::S_IDLE);
    rd_en          = 1'b0;

    case (state)
      fpfa_pkg::S_IDLE: begin
        if (in_valid) begin
          rd_en = 1'b1;
          case (fpfa_pkg::op_t'(op))
            fpfa_pkg::OP_ALLOC: begin
              // mark the head frame mapped now, link read comes back next cycle
              if (!list_empty) begin
                map_we = 1'b1;
                map_wa = head_index;
                map_wd = 1'b1;
              end
              state_next = fpfa_pkg::S_EXEC;
            end
            fpfa_pkg::OP_BUILD: begin
              limit_next = build_frames;
              base_next  = heap_base;
              cnt_next   = '0;
              state_next = fpfa_pkg::S_BUILD;
            end
            default: begin
              state_next = fpfa_pkg::S_EXEC;
            end
          endcase
        end
      end

      fpfa_pkg::S_EXEC: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          granted_next   = '0;
          status_next    = fpfa_pkg::ST_OK;
          state_next     = fpfa_pkg::S_IDLE;
          case (op_q)
            fpfa_pkg::OP_ALLOC: begin
              if (list_empty) begin
                status_next = fpfa_pkg::ST_EMPTY;
              end else begin
                granted_next = built_base + (32'(head_index) << PS);
                if (head_index == tail_index) begin
                  empty_next = 1'b1;
                end else begin
                  head_next = link_rdata;
                end
              end
            end
            fpfa_pkg::OP_FREE: begin
              if (!range_ok) begin
                status_next = fpfa_pkg::ST_RANGE;
              end else if (!map_rdata) begin
                status_next = fpfa_pkg::ST_UNMAPPED;
              end else begin
                // clear mapped bit and append at the tail
                map_we  = 1'b1;
                map_wa  = idx_q;
                map_wd  = 1'b0;
                if (list_empty) begin
                  head_next  = idx_q;
                  empty_next = 1'b0;
                end else begin
                  link_we = 1'b1;
                  link_wa = tail_index;
                  link_wd = idx_q;
                end
                tail_next = idx_q;
              end
            end
            default: begin
            end
          endcase
        end
      end

      fpfa_pkg::S_BUILD: begin
        if (build_cnt < frames_in_use_limit) begin
          // one frame per cycle: unmapped, linked to the next one
          map_we   = 1'b1;
          map_wa   = build_cnt[IW-1:0];
          map_wd   = 1'b0;
          link_we  = 1'b1;
          link_wa  = build_cnt[IW-1:0];
          link_wd  = IW'(build_cnt + LW'(1));
          cnt_next = build_cnt + LW'(1);
        end else if (slot_free) begin
          head_next = '0;
          if (frames_in_use_limit == '0) begin
            tail_next  = '0;
            empty_next = 1'b1;
          end else begin
            tail_next  = IW'(frames_in_use_limit - LW'(1));
            empty_next = 1'b0;
          end
          out_valid_next = 1'b1;
          granted_next   = '0;
          status_next    = (33'(frames_in_use_limit) < 33'(MAX_FRAMES))
                           ? fpfa_pkg::ST_SHORT : fpfa_pkg::ST_OK;
          state_next     = fpfa_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = fpfa_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= fpfa_pkg::S_IDLE;
      head_index          <= '0;
      tail_index          <= '0;
      list_empty          <= 1'b1;
      frames_in_use_limit <= '0;
      built_base          <= '0;
      build_cnt           <= '0;
      out_valid           <= 1'b0;
      heap_base           <= '0;
      heap_bytes          <= '0;
    end else begin
      state               <= state_next;
      head_index          <= head_next;
      tail_index          <= tail_next;
      list_empty          <= empty_next;
      frames_in_use_limit <= limit_next;
      built_base          <= base_next;
      build_cnt           <= cnt_next;
      out_valid           <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fpfa_pkg::REG_HEAP_BASE:  heap_base  <= cfg_data;
          fpfa_pkg::REG_HEAP_BYTES: heap_bytes <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    granted_address <= granted_next;
    status          <= status_next;
    if (in_beat) begin
      op_q     <= fpfa_pkg::op_t'(op);
      idx_q    <= map_ra;
      range_ok <= free_in_range;
    end
  end

  // link memory: read the head link on the input beat
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (rd_en) begin
      link_rdata <= link_mem[head_index];
    end
  end

  // mapped-bit memory: read the freed frame's bit on the input beat
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (rd_en) begin
      map_rdata <= map_mem[map_ra];
    end
  end

  // an accepted beat always leaves idle
  a_beat_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> state != fpfa_pkg::S_IDLE)
    else $error("input beat did not start work");

  // any error status carries a zero address
  a_err_zero_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != fpfa_pkg::ST_OK |-> granted_address == '0)
    else $error("error result with nonzero address");

  // list pointers stay inside the built heap
  a_ptr_in_heap: assert property (@(posedge clk) disable iff (rst)
    state == fpfa_pkg::S_IDLE && !list_empty |->
      (LW'(head_index) < frames_in_use_limit) && (LW'(tail_index) < frames_in_use_limit))
    else $error("list pointer beyond built heap");

  // build sweep never passes the frame count
  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    state == fpfa_pkg::S_BUILD |-> build_cnt <= frames_in_use_limit)
    else $error("build sweep overran");

  // a result is produced only on the way back to idle
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> state == fpfa_pkg::S_IDLE)
    else $error("result raised outside completion");

endmodule
